/* sv/cgr_pkg.sv */
// Shared types, constants and rounding, saturation and sign helpers for the complex Givens rotation unit.
// No dependencies.
package cgr_pkg;

  localparam int IN_W     = 32;
  localparam int CS_W     = 32;
  localparam int RAD_W    = 34;
  localparam int SQ_IN_W  = 64;
  localparam int DIV_DW   = 33;
  localparam int DIV_QW   = 33;
  localparam int NUM_W    = DIV_DW + DIV_QW;
  localparam int FRAC_CS  = 30;
  localparam int SQ_LAT   = SQ_IN_W / 2;
  localparam int DIV_LAT  = DIV_QW;
  localparam int N_DIV    = 7;

  localparam logic signed [CS_W-1:0] ONE_Q30 = CS_W'(1) <<< FRAC_CS;

  typedef enum logic [2:0] {
    K_ZERO,
    K_REAL,
    K_BZERO,
    K_AZERO,
    K_GEN
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic                    neg_ar;
    logic                    neg_ai;
    logic                    neg_br;
    logic                    neg_bi;
    logic [4:0]              sh;
    logic                    ovf;
    logic [DIV_DW-1:0]       h;
    logic [IN_W-1:0]         nar;
    logic [IN_W-1:0]         nai;
    logic [IN_W-1:0]         nbr;
    logic [IN_W-1:0]         nbi;
    logic signed [IN_W-1:0]  ar;
    logic signed [IN_W-1:0]  ai;
    logic signed [IN_W-1:0]  br;
    logic signed [IN_W-1:0]  bi;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  // round to nearest on magnitude, ties away from zero, sign reapplied
  function automatic logic signed [NUM_W-1:0] rnd_shr(logic signed [NUM_W-1:0] x,
                                                       logic [4:0] sh);
    logic [NUM_W-1:0] m;
    logic [NUM_W-1:0] r;
    m = x[NUM_W-1] ? NUM_W'(-x) : NUM_W'(x);
    if (sh == 5'd0) begin
      r = m;
    end else begin
      r = (m + (NUM_W'(1) << (sh - 5'd1))) >> sh;
    end
    return x[NUM_W-1] ? -signed'(r) : signed'(r);
  endfunction

  function automatic logic signed [CS_W-1:0] sat_cs(logic signed [NUM_W-1:0] x);
    if (x > NUM_W'((64'sd1 <<< (CS_W-1)) - 64'sd1)) return {1'b0, {(CS_W-1){1'b1}}};
    if (x < -NUM_W'(64'sd1 <<< (CS_W-1))) return {1'b1, {(CS_W-1){1'b0}}};
    return x[CS_W-1:0];
  endfunction

  function automatic logic signed [RAD_W-1:0] sat_rad(logic signed [NUM_W-1:0] x);
    if (x > NUM_W'((64'sd1 <<< (RAD_W-1)) - 64'sd1)) return {1'b0, {(RAD_W-1){1'b1}}};
    if (x < -NUM_W'(64'sd1 <<< (RAD_W-1))) return {1'b1, {(RAD_W-1){1'b0}}};
    return x[RAD_W-1:0];
  endfunction

  function automatic logic signed [DIV_QW:0] apply_sign(logic neg, logic [DIV_QW-1:0] q);
    logic signed [DIV_QW:0] v;
    v = signed'({1'b0, q});
    return neg ? -v : v;
  endfunction

endpackage

/* sv/cgr_isqrt.sv */
// Pipelined floor integer square root, one root bit per stage.
// Depends on cgr_pkg.
module cgr_isqrt import cgr_pkg::*; #(
  parameter int IW = SQ_IN_W
) (
  input  logic              clk_i,
  input  logic [IW-1:0]     rad_i,
  output logic [IW/2-1:0]   root_o
);
  localparam int OW = IW / 2;
  localparam int RW = OW + 2;

  logic [RW-1:0] rem_q  [OW];
  logic [OW-1:0] root_q [OW];
  logic [IW-1:0] val_q  [OW];

  for (genvar k = 0; k < OW; k++) begin : g_st
    logic [RW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [IW-1:0] val_in;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
    end

    assign t     = {rem_in, val_in[IW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (t >= trial) begin
        rem_q[k]  <= RW'(t - trial);
        root_q[k] <= {root_in[OW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= t[RW-1:0];
        root_q[k] <= {root_in[OW-2:0], 1'b0};
      end
      val_q[k] <= val_in << 2;
    end
  end

  assign root_o = root_q[OW-1];

endmodule

/* sv/cgr_div.sv */
// Pipelined restoring divider, one quotient bit per stage; quotient must fit QW bits.
// Depends on cgr_pkg.
module cgr_div import cgr_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int QW = DIV_QW
) (
  input  logic               clk_i,
  input  logic [DW+QW-1:0]   num_i,
  input  logic [DW-1:0]      den_i,
  output logic [QW-1:0]      quo_o
);
  logic [DW-1:0] p_q   [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic [DW-1:0] d_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DW-1:0] p_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_in   = num_i[DW+QW-1:QW];
      assign low_in = num_i[QW-1:0];
      assign q_in   = '0;
      assign d_in   = den_i;
    end else begin : g_next
      assign p_in   = p_q[k-1];
      assign low_in = low_q[k-1];
      assign q_in   = q_q[k-1];
      assign d_in   = d_q[k-1];
    end

    assign t  = {p_in, low_in[QW-1]};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      p_q[k]   <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
      q_q[k]   <= {q_in[QW-2:0], ge};
      low_q[k] <= low_in << 1;
      d_q[k]   <= d_in;
    end
  end

  assign quo_o = q_q[QW-1];

endmodule

/* sv/cgr_delay.sv */
// Side-data delay line with reset valid bits, matched to an arithmetic pipeline.
// Depends on cgr_pkg.
module cgr_delay import cgr_pkg::*; #(
  parameter int W = SIDE_W,
  parameter int D = SQ_LAT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  logic [W-1:0] data_q [D];
  logic [D-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[D-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    for (int k = 1; k < D; k++) begin
      data_q[k] <= data_q[k-1];
    end
  end

  assign valid_o = vld_q[D-1];
  assign data_o  = data_q[D-1];

endmodule

/* sv/complex_givens_rotation.sv */
// Complex Givens rotation: items enter on start, one item per cycle, and leave on valid_o.
// The pipeline is built from the 32-stage square root pipeline and the 33-stage divider pipeline,
// plus seven pipeline registers around them. busy never rises; valid_o pulses one cycle.
// Asynchronous active-low reset clears all valid bits; payload registers are not reset.
// Depends on cgr_pkg, cgr_isqrt, cgr_div, cgr_delay.
module complex_givens_rotation import cgr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  first_re_i,
  input  logic signed [IN_W-1:0]  first_im_i,
  input  logic signed [IN_W-1:0]  second_re_i,
  input  logic signed [IN_W-1:0]  second_im_i,
  output logic                    valid_o,
  output logic signed [CS_W-1:0]  cosine_o,
  output logic signed [CS_W-1:0]  sine_re_o,
  output logic signed [CS_W-1:0]  sine_im_o,
  output logic signed [RAD_W-1:0] radius_re_o,
  output logic signed [RAD_W-1:0] radius_im_o
);
  localparam int TOTAL_LAT = SQ_LAT + DIV_LAT + 7;

  assign busy = 1'b0;

  // stage 1: classify, normalize
  side_t s1_d, s1_q, s2_q, s3_q;
  logic  v1_q, v2_q, v3_q;
  logic [IN_W-1:0] m_ar, m_ai, m_br, m_bi, m_or;
  logic [5:0] lz;

  function automatic logic [IN_W-1:0] mag32(logic signed [IN_W-1:0] v);
    return v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
  endfunction

  always_comb begin
    m_ar = mag32(first_re_i);
    m_ai = mag32(first_im_i);
    m_br = mag32(second_re_i);
    m_bi = mag32(second_im_i);
    m_or = m_ar | m_ai | m_br | m_bi;
    lz = 6'd32;
    for (int i = 0; i < IN_W; i++) begin
      if (m_or[i]) lz = 6'(IN_W - 1 - i);
    end
    s1_d = '0;
    if (first_im_i == '0 && second_im_i == '0) begin
      s1_d.kind = (first_re_i == '0 && second_re_i == '0) ? K_ZERO : K_REAL;
    end else if (second_re_i == '0 && second_im_i == '0) begin
      s1_d.kind = K_BZERO;
    end else if (first_re_i == '0 && first_im_i == '0) begin
      s1_d.kind = K_AZERO;
    end else begin
      s1_d.kind = K_GEN;
    end
    s1_d.sh     = (lz <= 6'd1) ? 5'd0 : 5'(lz - 6'd1);
    s1_d.neg_ar = first_re_i[IN_W-1];
    s1_d.neg_ai = first_im_i[IN_W-1];
    s1_d.neg_br = second_re_i[IN_W-1];
    s1_d.neg_bi = second_im_i[IN_W-1];
    s1_d.nar    = m_ar << s1_d.sh;
    s1_d.nai    = m_ai << s1_d.sh;
    s1_d.nbr    = m_br << s1_d.sh;
    s1_d.nbi    = m_bi << s1_d.sh;
    s1_d.ar     = first_re_i;
    s1_d.ai     = first_im_i;
    s1_d.br     = second_re_i;
    s1_d.bi     = second_im_i;
  end

  // stage 2: squares; stage 3: sums of squares
  logic [SQ_IN_W-1:0] sq_q [4];
  logic [SQ_IN_W:0]   sum_all;
  logic [SQ_IN_W-1:0] a2_d;

  assign a2_d    = sq_q[0] + sq_q[1];
  assign sum_all = {1'b0, a2_d} + {1'b0, sq_q[2]} + {1'b0, sq_q[3]};

  always_ff @(posedge clk_i) begin
    s1_q    <= s1_d;
    sq_q[0] <= SQ_IN_W'(s1_q.nar) * SQ_IN_W'(s1_q.nar);
    sq_q[1] <= SQ_IN_W'(s1_q.nai) * SQ_IN_W'(s1_q.nai);
    sq_q[2] <= SQ_IN_W'(s1_q.nbr) * SQ_IN_W'(s1_q.nbr);
    sq_q[3] <= SQ_IN_W'(s1_q.nbi) * SQ_IN_W'(s1_q.nbi);
    s2_q    <= s1_q;
  end

  side_t s3_d;
  always_comb begin
    s3_d     = s2_q;
    s3_d.ovf = sum_all[SQ_IN_W];
  end

  logic [SQ_IN_W-1:0] rad_s_q, rad_a_q;
  always_ff @(posedge clk_i) begin
    s3_q    <= s3_d;
    rad_s_q <= sum_all[SQ_IN_W-1:0];
    rad_a_q <= a2_d;
  end

  // square roots
  logic [SQ_IN_W/2-1:0] root_h, root_a;
  side_t sq_side;
  logic  sq_vld;

  cgr_isqrt #(.IW(SQ_IN_W)) u_sqrt_h (.clk_i, .rad_i(rad_s_q), .root_o(root_h));
  cgr_isqrt #(.IW(SQ_IN_W)) u_sqrt_a (.clk_i, .rad_i(rad_a_q), .root_o(root_a));

  cgr_delay #(.W(SIDE_W), .D(SQ_LAT)) u_dly_sq (
    .clk_i, .rst_ni, .valid_i(v3_q), .data_i(s3_q), .valid_o(sq_vld), .data_o(sq_side)
  );

  // stage M: radius, products for r
  side_t sm_d, sm_q;
  logic  vm_q;
  logic [IN_W-1:0]     ma_q;
  logic [DIV_DW+IN_W-1:0] pr_r_q, pr_i_q;

  always_comb begin
    sm_d   = sq_side;
    sm_d.h = sq_side.ovf ? (DIV_DW'(1) << IN_W) : DIV_DW'(root_h);
  end

  always_ff @(posedge clk_i) begin
    sm_q   <= sm_d;
    ma_q   <= root_a;
    pr_r_q <= (DIV_DW+IN_W)'(sq_side.nar) * (DIV_DW+IN_W)'(sm_d.h);
    pr_i_q <= (DIV_DW+IN_W)'(sq_side.nai) * (DIV_DW+IN_W)'(sm_d.h);
  end

  // stage N: dividends and divisors
  side_t sn_q;
  logic  vn_q;
  logic [NUM_W-1:0]  num_q [N_DIV];
  logic [DIV_DW-1:0] den_q [N_DIV];
  logic [IN_W-1:0]   x0;
  logic [NUM_W-1:0]  half_h, half_a;

  assign x0     = (sm_q.kind == K_REAL) ? sm_q.nar : ma_q;
  assign half_h = NUM_W'(sm_q.h >> 1);
  assign half_a = NUM_W'(ma_q >> 1);

  always_ff @(posedge clk_i) begin
    sn_q     <= sm_q;
    num_q[0] <= (NUM_W'(x0) << FRAC_CS) + half_h;
    den_q[0] <= sm_q.h;
    num_q[1] <= (NUM_W'(sm_q.nar) << FRAC_CS) + half_a;
    den_q[1] <= DIV_DW'(ma_q);
    num_q[2] <= (NUM_W'(sm_q.nai) << FRAC_CS) + half_a;
    den_q[2] <= DIV_DW'(ma_q);
    num_q[3] <= (NUM_W'(sm_q.nbr) << FRAC_CS) + half_h;
    den_q[3] <= sm_q.h;
    num_q[4] <= (NUM_W'(sm_q.nbi) << FRAC_CS) + half_h;
    den_q[4] <= sm_q.h;
    num_q[5] <= NUM_W'(pr_r_q) + half_a;
    den_q[5] <= DIV_DW'(ma_q);
    num_q[6] <= NUM_W'(pr_i_q) + half_a;
    den_q[6] <= DIV_DW'(ma_q);
  end

  // dividers
  logic [DIV_QW-1:0] quo [N_DIV];
  side_t dv_side;
  logic  dv_vld;

  for (genvar k = 0; k < N_DIV; k++) begin : g_div
    cgr_div #(.DW(DIV_DW), .QW(DIV_QW)) u_div (
      .clk_i, .num_i(num_q[k]), .den_i(den_q[k]), .quo_o(quo[k])
    );
  end

  cgr_delay #(.W(SIDE_W), .D(DIV_LAT)) u_dly_div (
    .clk_i, .rst_ni, .valid_i(vn_q), .data_i(sn_q), .valid_o(dv_vld), .data_o(dv_side)
  );

  // stage P: signed ratios and sine products
  side_t sp_q;
  logic  vp_q;
  logic signed [DIV_QW:0]    c_sgn, s_sgn, rre_g, rim_g;
  logic signed [CS_W-1:0]    ure, uim, vre, vim;
  logic signed [DIV_QW:0]    c_p_q, s_real_q, rre_q, rim_q;
  logic signed [2*CS_W-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [DIV_QW:0]    t_ur, t_ui, t_vr, t_vi;

  always_comb begin
    c_sgn = apply_sign(dv_side.neg_ar && dv_side.kind == K_REAL, quo[0]);
    s_sgn = apply_sign(dv_side.neg_br, quo[3]);
    t_ur  = apply_sign(dv_side.neg_ar, quo[1]);
    t_ui  = apply_sign(dv_side.neg_ai, quo[2]);
    t_vr  = apply_sign(dv_side.neg_br, quo[3]);
    t_vi  = apply_sign(!dv_side.neg_bi, quo[4]);
    ure   = t_ur[CS_W-1:0];
    uim   = t_ui[CS_W-1:0];
    vre   = t_vr[CS_W-1:0];
    vim   = t_vi[CS_W-1:0];
    rre_g = apply_sign(dv_side.neg_ar, quo[5]);
    rim_g = apply_sign(dv_side.neg_ai, quo[6]);
  end

  always_ff @(posedge clk_i) begin
    sp_q     <= dv_side;
    c_p_q    <= c_sgn;
    s_real_q <= s_sgn;
    rre_q    <= rre_g;
    rim_q    <= rim_g;
    p_rr_q   <= ure * vre;
    p_ii_q   <= uim * vim;
    p_ri_q   <= ure * vim;
    p_ir_q   <= uim * vre;
  end

  // stage O: combine, round, saturate, select case
  logic signed [CS_W-1:0]  c_d, sre_d, sim_d;
  logic signed [RAD_W-1:0] rre_d, rim_d;
  logic signed [NUM_W-1:0] sre_raw, sim_raw;

  always_comb begin
    sre_raw = NUM_W'(p_rr_q) - NUM_W'(p_ii_q);
    sim_raw = NUM_W'(p_ri_q) + NUM_W'(p_ir_q);
    c_d   = '0;
    sre_d = '0;
    sim_d = '0;
    rre_d = '0;
    rim_d = '0;
    case (sp_q.kind)
      K_ZERO: begin
        c_d = ONE_Q30;
      end
      K_REAL: begin
        c_d   = sat_cs(NUM_W'(c_p_q));
        sre_d = sat_cs(NUM_W'(s_real_q));
        rre_d = sat_rad(rnd_shr(signed'(NUM_W'(sp_q.h)), sp_q.sh));
      end
      K_BZERO: begin
        c_d   = ONE_Q30;
        rre_d = RAD_W'(sp_q.ar);
        rim_d = RAD_W'(sp_q.ai);
      end
      K_AZERO: begin
        sre_d = ONE_Q30;
        rre_d = RAD_W'(sp_q.br);
        rim_d = RAD_W'(sp_q.bi);
      end
      K_GEN: begin
        c_d   = sat_cs(NUM_W'(c_p_q));
        sre_d = sat_cs(rnd_shr(sre_raw, 5'(FRAC_CS)));
        sim_d = sat_cs(rnd_shr(sim_raw, 5'(FRAC_CS)));
        rre_d = sat_rad(rnd_shr(NUM_W'(rre_q), sp_q.sh));
        rim_d = sat_rad(rnd_shr(NUM_W'(rim_q), sp_q.sh));
      end
      default: begin
        c_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cosine_o    <= c_d;
    sine_re_o   <= sre_d;
    sine_im_o   <= sim_d;
    radius_re_o <= rre_d;
    radius_im_o <= rim_d;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vm_q    <= 1'b0;
      vn_q    <= 1'b0;
      vp_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= start && !busy;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vm_q    <= sq_vld;
      vn_q    <= vm_q;
      vp_q    <= dv_vld;
      valid_o <= vp_q;
    end
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, TOTAL_LAT))
    else $error("result strobe without matching item");

  a_ovf_general: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && s3_q.ovf) |-> (s3_q.kind == K_GEN))
    else $error("sum of squares overflow outside general case");

  a_zero_cos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && first_re_i == '0 && first_im_i == '0 &&
     second_re_i == '0 && second_im_i == '0)
    |-> ##TOTAL_LAT (valid_o && cosine_o == ONE_Q30))
    else $error("zero item did not give unit cosine");

endmodule

/* verif/tb_complex_givens_rotation.sv */
// Testbench for complex_givens_rotation: directed corner items, then random items under
// several sender idle patterns, checked against a behavioral rotation predictor.
// Depends on cgr_pkg and the complex_givens_rotation RTL.
`timescale 1ns / 1ps
module tb_complex_givens_rotation;
  import cgr_pkg::*;

  localparam int LATENCY = 72;
  localparam longint MAX_CYCLES = 400000;

  typedef struct {
    logic signed [CS_W-1:0]  cosine;
    logic signed [CS_W-1:0]  sine_re;
    logic signed [CS_W-1:0]  sine_im;
    logic signed [RAD_W-1:0] radius_re;
    logic signed [RAD_W-1:0] radius_im;
  } rotation_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] first_re_i = '0, first_im_i = '0, second_re_i = '0, second_im_i = '0;
  logic valid_o;
  logic signed [CS_W-1:0] cosine_o, sine_re_o, sine_im_o;
  logic signed [RAD_W-1:0] radius_re_o, radius_im_o;

  rotation_t pending_rot[$];
  int mismatches = 0;
  int idle_pct = 0;
  longint cycles = 0;

  complex_givens_rotation uut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("complex_givens_rotation test failed");
      $finish;
    end
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_of(bit neg, longint unsigned m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned div_rnd(longint unsigned n, longint unsigned d);
    return d == 0 ? 0 : (n + d / 2) / d;
  endfunction

  function automatic longint rnd_right(longint x, int sh);
    if (sh == 0) return x;
    return signed_of(x < 0, (mag(x) + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint q30_ratio(longint x, longint unsigned d);
    return signed_of(x < 0, div_rnd(mag(x) << 30, d));
  endfunction

  function automatic int align_shift(longint unsigned m);
    int sh;
    sh = 0;
    if (m == 0) return 0;
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      sh++;
    end
    return sh;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic rotation_t predict_rotation(longint ar, longint ai, longint br, longint bi);
    rotation_t r;
    longint c, sre, sim, rre, rim, ure, uim, vre, vim;
    longint unsigned h, a2, b2, s2, ma, m;
    int sh;
    c = 0; sre = 0; sim = 0; rre = 0; rim = 0;
    if (ai == 0 && bi == 0) begin
      if (ar == 0 && br == 0) begin
        c = 64'd1 << 30;
      end else begin
        m = mag(ar) > mag(br) ? mag(ar) : mag(br);
        sh = align_shift(m);
        ar = ar * (longint'(1) << sh);
        br = br * (longint'(1) << sh);
        h = int_sqrt(mag(ar) * mag(ar) + mag(br) * mag(br));
        c = q30_ratio(ar, h);
        sre = q30_ratio(br, h);
        rre = rnd_right(longint'(h), sh);
      end
    end else if (br == 0 && bi == 0) begin
      c = 64'd1 << 30; rre = ar; rim = ai;
    end else if (ar == 0 && ai == 0) begin
      sre = 64'd1 << 30; rre = br; rim = bi;
    end else begin
      m = mag(ar);
      if (mag(ai) > m) m = mag(ai);
      if (mag(br) > m) m = mag(br);
      if (mag(bi) > m) m = mag(bi);
      sh = align_shift(m);
      ar = ar * (longint'(1) << sh);
      ai = ai * (longint'(1) << sh);
      br = br * (longint'(1) << sh);
      bi = bi * (longint'(1) << sh);
      a2 = mag(ar) * mag(ar) + mag(ai) * mag(ai);
      b2 = mag(br) * mag(br) + mag(bi) * mag(bi);
      s2 = a2 + b2;
      h = (s2 < a2) ? (64'd1 << 32) : int_sqrt(s2);
      ma = int_sqrt(a2);
      c = div_rnd(ma << 30, h);
      ure = q30_ratio(ar, ma);
      uim = q30_ratio(ai, ma);
      vre = q30_ratio(br, h);
      vim = -q30_ratio(bi, h);
      sre = rnd_right(ure * vre - uim * vim, 30);
      sim = rnd_right(ure * vim + uim * vre, 30);
      rre = rnd_right(signed_of(ar < 0, div_rnd(mag(ar) * h, ma)), sh);
      rim = rnd_right(signed_of(ai < 0, div_rnd(mag(ai) * h, ma)), sh);
    end
    r.cosine = CS_W'(clamp(c, CS_W));
    r.sine_re = CS_W'(clamp(sre, CS_W));
    r.sine_im = CS_W'(clamp(sim, CS_W));
    r.radius_re = RAD_W'(clamp(rre, RAD_W));
    r.radius_im = RAD_W'(clamp(rim, RAD_W));
    return r;
  endfunction

  task automatic send_item(logic signed [IN_W-1:0] ar, ai, br, bi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    first_re_i <= ar;
    first_im_i <= ai;
    second_re_i <= br;
    second_im_i <= bi;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rot.push_back(predict_rotation(ar, ai, br, bi));
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rotation_t e;
    if (rst_ni && valid_o) begin
      if (pending_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected rotation result at cycle %0d", cycles);
      end else begin
        e = pending_rot.pop_front();
        if (cosine_o !== e.cosine || sine_re_o !== e.sine_re || sine_im_o !== e.sine_im ||
            radius_re_o !== e.radius_re || radius_im_o !== e.radius_im) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp c=%0d s=%0d,%0d r=%0d,%0d got c=%0d s=%0d,%0d r=%0d,%0d",
                     e.cosine, e.sine_re, e.sine_im, e.radius_re, e.radius_im, cosine_o,
                     sine_re_o, sine_im_o, radius_re_o, radius_im_o);
        end
      end
    end
  end

  function automatic logic signed [IN_W-1:0] rand_field();
    case ($urandom_range(5))
      0: return '0;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed(32'($urandom_range(255))) - 128;
      3: return $signed($urandom) >>> $urandom_range(31);
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic test_corners();
    localparam logic signed [IN_W-1:0] MAXV = 32'sh7fffffff, MINV = 32'sh80000000;
    idle_pct = 0;
    send_item(0, 0, 0, 0);
    send_item(MAXV, 0, 0, 0);
    send_item(MINV, 0, 0, 0);
    send_item(0, 0, MAXV, 0);
    send_item(0, 0, MINV, 0);
    send_item(3 << 16, 0, 4 << 16, 0);
    send_item(-1, 0, 1, 0);
    send_item(MINV, 0, MINV, 0);
    send_item(5, 7, 0, 0);
    send_item(MINV, MAXV, 0, 0);
    send_item(0, 0, -9, 3);
    send_item(0, 0, MAXV, MINV);
    send_item(0, 1, 0, 0);
    send_item(0, 0, 0, -1);
    send_item(MINV, MINV, MINV, MINV);
    send_item(MAXV, MAXV, MAXV, MAXV);
    send_item(1, 1, 1, 1);
    send_item(-1, 2, MAXV, -3);
    send_item(1 << 16, -(1 << 16), 0, 1 << 16);
    send_item(0, MINV, 1, 0);
    end_burst();
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    repeat (n) send_item(rand_field(), rand_field(), rand_field(), rand_field());
    end_burst();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_corners();
    test_random(250, 0);
    test_random(200, 82);
    test_random(200, 11);
    test_random(150, 0);
    while (pending_rot.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("complex_givens_rotation test passed");
    end else begin
      $display("complex_givens_rotation test failed");
    end
    $finish;
  end

endmodule
